// ===== rtl/slrr_pkg.sv =====
// Package for the shuffled Lehmer random range core.
// Holds constants, sequencer states, divider handshake types and the Lehmer fold.
// No dependencies.
package slrr_pkg;

	localparam int unsigned TABLE_SIZE_DEF = 32;
	localparam int unsigned WARM_DISCARD   = 8;
	localparam int unsigned PROD_W         = 47;

	localparam logic [14:0] LEHMER_MULT = 15'd16807;
	localparam logic [30:0] LEHMER_MOD  = 31'h7FFF_FFFF;
	localparam logic [31:0] RANGE_TOP   = 32'h7FFF_FFFF;
	localparam logic [31:0] RANGE_ONE   = 32'h8000_0000;

	localparam logic ACT_RAW   = 1'b0;
	localparam logic ACT_RANGE = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SETUP,
		S_BOUND,
		S_CHECK,
		S_WARM_MUL,
		S_WARM_FOLD,
		S_DRAW_MUL,
		S_DRAW_FOLD,
		S_DRAW_WAIT,
		S_READ,
		S_WRITE,
		S_MOD,
		S_DONE
	} slrr_state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} slrr_div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] remainder;
	} slrr_div_rsp_t;

	// Reduce a product below 2^47 modulo 2^31 - 1 by folding the high part.
	function automatic logic [30:0] lehmer_fold(input logic [PROD_W-1:0] p);
		logic [31:0] s;
		s = {16'b0, p[46:31]} + {1'b0, p[30:0]};
		if (s >= {1'b0, LEHMER_MOD}) begin
			s = s - {1'b0, LEHMER_MOD};
		end
		return s[30:0];
	endfunction

endpackage

// ===== rtl/slrr_if.sv =====
// Valid/ready channel interfaces for the shuffled Lehmer random range core.
// No dependencies.
interface slrr_item_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [31:0] range_low;
	logic signed [31:0] range_high;

	modport source (output valid, output action, output range_low, output range_high,
		input ready);
	modport sink (input valid, input action, input range_low, input range_high,
		output ready);
endinterface

interface slrr_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface slrr_cfg_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] seed;

	modport source (output valid, output seed, input ready);
	modport sink (input valid, input seed, output ready);
endinterface

// ===== rtl/shuffled_lehmer_random_range_core.sv =====
// Top level of the shuffled Lehmer random range core (minimal-standard Lehmer
// generator, Bays-Durham shuffle, rejection-sampled range draws).
// Depends on slrr_pkg, slrr_if, slrr_ram and slrr_div.
//
//  channel  role    beat contents                     handshake
//  -------  ------  --------------------------------  ---------------------
//  item     sink    action, range_low, range_high     valid & ready
//  result   source  value                             valid & ready
//  cfg      sink    seed                              valid & ready (always)
//
// A raw draw runs the check, one Lehmer multiply and fold, the index search,
// a table read and write and the final state; the shuffle index is found one
// bit per cycle by comparing the last output against multiples of the shuffle
// divisor. A warm-up adds one multiply and one fold per Lehmer step. A ranged
// draw adds a setup step, a divide for the acceptance bound, a divide for the
// final modulo and a fresh draw for each rejected candidate. Degenerate spans
// go from setup straight to the final state. The item port opens again on the
// same edge that loads the result register.
// Reset clears the sequencer, the Lehmer value, the last output and the seed,
// and flags a warm-up; the shuffle table is not cleared. A result that waits
// on a stalled sink still lets the next item in; the item then holds in the
// final state until the output register frees up.
module shuffled_lehmer_random_range_core
	import slrr_pkg::*;
#(
	parameter int unsigned TABLE_SIZE = TABLE_SIZE_DEF
) (
	input logic       clk,
	input logic       arst_n,
	slrr_item_if.sink   item,
	slrr_result_if.source result,
	slrr_cfg_if.sink    cfg
);

	localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
	localparam int unsigned CNT_W = $clog2(TABLE_SIZE + WARM_DISCARD);
	localparam int unsigned THR_W = IDX_W + 32;
	localparam logic [CNT_W-1:0] WARM_LAST = CNT_W'(TABLE_SIZE + WARM_DISCARD - 1);
	localparam logic [CNT_W-1:0] TABLE_CNT = CNT_W'(TABLE_SIZE);
	localparam logic [CNT_W-1:0] IDX_TOP   = CNT_W'(IDX_W - 1);
	// Shuffle divisor: 1 + (2^31 - 2) / TABLE_SIZE
	localparam logic [31:0] SHUFFLE_DIV = 32'(1 + (32'h7FFF_FFFE / TABLE_SIZE));

	// Sequencer and control state
	slrr_state_t state_q, state_d;
	logic        warm_q;
	logic [31:0] seed_q;
	logic [31:0] x_q;        // Lehmer value; can hold 2^31 at warm-up start
	logic [30:0] last_q;
	logic        out_valid_q;

	// Datapath registers
	logic              action_q;
	logic [31:0]       lo_q;
	logic [31:0]       hi_q;
	logic [31:0]       span_q;
	logic [30:0]       bound_q;
	logic [PROD_W-1:0] prod_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  j_q;
	logic [31:0]       result_q;
	logic [31:0]       value_q;

	// Shared units
	slrr_div_req_t div_req;
	slrr_div_rsp_t div_rsp;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [30:0]      ram_wdata;
	logic [30:0]      ram_rdata;

	// Combinational helpers
	logic [31:0] diff;
	logic        degenerate;
	logic        need_warm;
	logic [31:0] seed_mag;
	logic [31:0] warm_start;
	logic [30:0] fold;
	logic        out_free;
	logic        reject;
	logic [IDX_W-1:0] j_trial;
	logic [THR_W-1:0] j_thresh;
	logic             j_fits;

	always_comb begin
		diff       = hi_q - lo_q;
		// span of 0 or 1, or above 2^31
		degenerate = diff[31] || (diff == 32'd0);
		need_warm  = warm_q || (x_q == 32'd0) || (last_q == 31'd0);
		seed_mag   = seed_q[31] ? (32'd0 - seed_q) : seed_q;
		if (warm_q) begin
			warm_start = (seed_mag == 32'd0) ? 32'd1 : seed_mag;
		end else begin
			warm_start = (x_q == 32'd0) ? 32'd1 : x_q;
		end
		fold     = lehmer_fold(prod_q);
		out_free = !out_valid_q || result.ready;
		reject   = (ram_rdata > bound_q);
		// try the next index bit: keep it if its multiple of the divisor still fits
		j_trial  = j_q | (IDX_W'(1) << cnt_q);
		j_thresh = THR_W'(j_trial) * THR_W'(SHUFFLE_DIV);
		j_fits   = (THR_W'(last_q) >= j_thresh);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					state_d = (item.action == ACT_RANGE) ? S_SETUP : S_CHECK;
				end
			end
			S_SETUP:     state_d = degenerate ? S_DONE : S_BOUND;
			S_BOUND:     state_d = div_rsp.done ? S_CHECK : S_BOUND;
			S_CHECK:     state_d = need_warm ? S_WARM_MUL : S_DRAW_MUL;
			S_WARM_MUL:  state_d = S_WARM_FOLD;
			S_WARM_FOLD: state_d = (cnt_q == '0) ? S_DRAW_MUL : S_WARM_MUL;
			S_DRAW_MUL:  state_d = S_DRAW_FOLD;
			S_DRAW_FOLD: state_d = S_DRAW_WAIT;
			S_DRAW_WAIT: state_d = (cnt_q == '0) ? S_READ : S_DRAW_WAIT;
			S_READ:      state_d = S_WRITE;
			S_WRITE: begin
				if (action_q == ACT_RAW) begin
					state_d = S_DONE;
				end else begin
					state_d = reject ? S_CHECK : S_MOD;
				end
			end
			S_MOD:  state_d = div_rsp.done ? S_DONE : S_MOD;
			S_DONE: state_d = out_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// Unit controls
	always_comb begin
		div_req   = '0;
		ram_we    = 1'b0;
		ram_waddr = j_q;
		ram_wdata = x_q[30:0];
		unique case (state_q)
			S_SETUP: begin
				div_req.start    = !degenerate;
				div_req.dividend = RANGE_ONE;
				div_req.divisor  = diff + 32'd1;
			end
			S_WARM_FOLD: begin
				ram_we    = (cnt_q < TABLE_CNT);
				ram_waddr = cnt_q[IDX_W-1:0];
				ram_wdata = fold;
			end
			S_WRITE: begin
				ram_we           = 1'b1;
				div_req.start    = (action_q == ACT_RANGE) && !reject;
				div_req.dividend = {1'b0, ram_rdata};
				div_req.divisor  = span_q;
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			warm_q      <= 1'b1;
			seed_q      <= '0;
			x_q         <= '0;
			last_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// a seed write flags a warm-up; the last warm-up step clears the flag
			if (cfg.valid && cfg.ready) begin
				seed_q <= cfg.seed;
				warm_q <= 1'b1;
			end else if ((state_q == S_WARM_FOLD) && (cnt_q == '0)) begin
				warm_q <= 1'b0;
			end
			// load a new result beat, or drop the one the sink just took
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CHECK: begin
					if (need_warm) begin
						x_q <= warm_start;
					end
				end
				S_WARM_FOLD: begin
					x_q <= {1'b0, fold};
					if (cnt_q == '0) begin
						last_q <= fold;
					end
				end
				S_DRAW_FOLD: x_q <= {1'b0, fold};
				S_WRITE:     last_q <= ram_rdata;
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				action_q <= item.action;
				lo_q     <= item.range_low;
				hi_q     <= item.range_high;
			end
			S_SETUP: begin
				span_q   <= diff + 32'd1;
				result_q <= lo_q;
			end
			S_BOUND: begin
				if (div_rsp.done) begin
					bound_q <= 31'(RANGE_TOP - div_rsp.remainder);
				end
			end
			S_CHECK:     cnt_q <= WARM_LAST;
			S_WARM_MUL:  prod_q <= PROD_W'(x_q) * PROD_W'(LEHMER_MULT);
			S_WARM_FOLD: cnt_q <= cnt_q - CNT_W'(1);
			S_DRAW_MUL: begin
				prod_q <= PROD_W'(x_q) * PROD_W'(LEHMER_MULT);
				// start the index search from the top bit
				j_q    <= '0;
				cnt_q  <= IDX_TOP;
			end
			S_DRAW_WAIT: begin
				if (j_fits) begin
					j_q <= j_trial;
				end
				cnt_q <= cnt_q - CNT_W'(1);
			end
			S_WRITE: result_q <= {1'b0, ram_rdata};
			S_MOD: begin
				if (div_rsp.done) begin
					result_q <= lo_q + div_rsp.remainder;
				end
			end
			S_DONE: begin
				if (out_free) begin
					value_q <= result_q;
				end
			end
			default: begin
			end
		endcase
	end

	slrr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	slrr_ram #(
		.WIDTH (31),
		.DEPTH (TABLE_SIZE)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (j_q),
		.rdata (ram_rdata)
	);

	// Ports
	assign item.ready   = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign result.valid = out_valid_q;
	assign result.value = value_q;

endmodule

// ===== rtl/slrr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slrr_ram #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/slrr_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on slrr_pkg for the request and response types.
module slrr_div
	import slrr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  slrr_div_req_t req,
	output slrr_div_rsp_t rsp
);

	logic [31:0] dvd_q;
	logic [31:0] dsr_q;
	logic [31:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [32:0] trial;
	logic        fits;
	logic [32:0] diff;

	always_comb begin
		trial = {rem_q, dvd_q[31]};
		fits  = (trial >= {1'b0, dsr_q});
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			// shift the next dividend bit in, subtract if it fits
			rem_q <= fits ? diff[31:0] : trial[31:0];
			dvd_q <= {dvd_q[30:0], fits};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== rtl/slrr_checker.sv =====
// Port-level checks for the shuffled Lehmer random range core.
// Depends on the top level's ports; bound to it below.
module slrr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_value,
	input logic        cfg_ready
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value))
		else $error("result beat dropped or changed while stalled");

	// drop ready once an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item still at work");

	// a new result shows only out of a busy sequencer
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work in flight");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("seed write not taken");

endmodule

bind shuffled_lehmer_random_range_core slrr_checker u_slrr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_value (result.value),
	.cfg_ready (cfg.ready)
);
